// ===== rtl/core/cfu_pkg.sv =====
package cfu_pkg;

  // stack depth is a power of two so the pointer indexes by part-select
  localparam int unsigned STACK_DEPTH = 256;
  localparam int unsigned STACK_AW    = $clog2(STACK_DEPTH);

  typedef enum logic [3:0] {
    REQ_JMP_ABS = 4'd0,
    REQ_JMP_IND = 4'd1,
    REQ_JSR     = 4'd2,
    REQ_RTS     = 4'd3,
    REQ_BCC     = 4'd4,
    REQ_BCS     = 4'd5,
    REQ_BNE     = 4'd6,
    REQ_BEQ     = 4'd7,
    REQ_BVC     = 4'd8,
    REQ_BVS     = 4'd9,
    REQ_BPL     = 4'd10,
    REQ_BMI     = 4'd11,
    REQ_BRK     = 4'd12,
    REQ_RTI     = 4'd13
  } cfu_req_e;

  typedef enum logic [1:0] {
    STS_NORMAL = 2'd0,
    STS_TAKEN  = 2'd1,
    STS_CROSS  = 2'd2
  } cfu_sts_e;

  // stack activity class of a request
  typedef enum logic [2:0] {
    OP_PLAIN,
    OP_JSR,
    OP_BRK,
    OP_RTS,
    OP_RTI
  } cfu_op_e;

  // byte slots of a push or pop sequence
  localparam logic [1:0] SLOT_0 = 2'd0;
  localparam logic [1:0] SLOT_1 = 2'd1;
  localparam logic [1:0] SLOT_2 = 2'd2;

  typedef struct packed {
    logic       latch;
    logic       push;
    logic [1:0] push_idx;
    logic       pop;
    logic       cap;
    logic [1:0] cap_idx;
    logic       finish;
  } cfu_cmd_t;

  typedef struct packed {
    cfu_op_e in_op;
    logic    out_free;
  } cfu_stat_t;

  function automatic cfu_op_e op_class(logic [3:0] req);
    cfu_op_e op;
    unique case (req)
      REQ_JSR: op = OP_JSR;
      REQ_BRK: op = OP_BRK;
      REQ_RTS: op = OP_RTS;
      REQ_RTI: op = OP_RTI;
      default: op = OP_PLAIN;
    endcase
    return op;
  endfunction

endpackage

// ===== rtl/core/cfu_if.sv =====
interface cfu_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  req_type;
  logic [15:0] operand;
  logic [15:0] jump_word;
  logic [15:0] current_pc;
  logic [7:0]  flags_in;

  modport source (output valid, req_type, operand, jump_word, current_pc, flags_in,
                  input ready);
  modport sink (input valid, req_type, operand, jump_word, current_pc, flags_in,
                output ready);
endinterface

interface cfu_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_pc;
  logic [7:0]  flags_out;
  logic [1:0]  branch_status;
  logic [7:0]  stack_pointer_out;

  modport source (output valid, next_pc, flags_out, branch_status, stack_pointer_out,
                  input ready);
  modport sink (input valid, next_pc, flags_out, branch_status, stack_pointer_out,
                output ready);
endinterface

// ===== rtl/core/cpu6502_control_flow_unit.sv =====
// 6502 control-flow unit: jumps, JSR/RTS, the eight flag branches, BRK and RTI,
// with the stack pointer and an on-chip stack page.
// req_i carries one instruction request (type, operand, indirect word, PC,
// status byte); rsp_o returns next PC, status byte, branch status and the
// stack pointer after the instruction. Both channels move a request on a
// rising edge where valid and ready are both high.
// cfg_we_i/cfg_data_i write break_target, the BRK handler address; the user
// must write it only while idle, which the block itself does not enforce.
// Jumps, branches and unused codes take no stack access; JSR pushes two bytes
// and BRK three (one stack write per cycle), RTS pops two and RTI three (one
// read per cycle, plus registered read data); the single stack memory port
// sets this pace. A new request is taken the cycle after the result is loaded
// into the output register. A result waits there while rsp_o.ready is low;
// the next request may be accepted and run, but its result is held until the
// output register is free.
// Reset sets the stack pointer to 0xFF and break_target to zero; stack
// bytes are undefined until pushed and take no clearing pass.
module cpu6502_control_flow_unit
  import cfu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  cfu_req_if.sink     req_i,
  cfu_rsp_if.source   rsp_o
);

  cfu_cmd_t  cmd;
  cfu_stat_t stat;
  logic      in_ready;

  assign req_i.ready = in_ready;

  cfu_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(req_i.valid),
    .in_ready_o(in_ready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  cfu_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_data_i         (cfg_data_i),
    .req_type_i         (req_i.req_type),
    .operand_i          (req_i.operand),
    .jump_word_i        (req_i.jump_word),
    .current_pc_i       (req_i.current_pc),
    .flags_in_i         (req_i.flags_in),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .out_valid_o        (rsp_o.valid),
    .out_ready_i        (rsp_o.ready),
    .next_pc_o          (rsp_o.next_pc),
    .flags_out_o        (rsp_o.flags_out),
    .branch_status_o    (rsp_o.branch_status),
    .stack_pointer_out_o(rsp_o.stack_pointer_out)
  );

endmodule

// ===== rtl/core/cfu_ram.sv =====
module cfu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/cfu_ctrl.sv =====
module cfu_ctrl
  import cfu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  cfu_stat_t stat_i,
  output cfu_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_POP,
    ST_LAST,
    ST_DONE
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] last_q, last_d;
  logic       ready_q, ready_d;
  logic       accept;

  assign accept     = in_valid_i & ready_q;
  assign in_ready_o = ready_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    last_d  = last_q;
    ready_d = ready_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.latch = 1'b1;
          ready_d     = 1'b0;
          cnt_d       = SLOT_0;
          unique case (stat_i.in_op)
            OP_JSR: begin
              state_d = ST_PUSH;
              last_d  = SLOT_1;
            end
            OP_BRK: begin
              state_d = ST_PUSH;
              last_d  = SLOT_2;
            end
            OP_RTS: begin
              state_d = ST_POP;
              last_d  = SLOT_1;
            end
            OP_RTI: begin
              state_d = ST_POP;
              last_d  = SLOT_2;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_PUSH: begin
        cmd_o.push     = 1'b1;
        cmd_o.push_idx = cnt_q;
        if (cnt_q == last_q) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 2'd1;
        end
      end
      ST_POP: begin
        // read data of the previous pop arrives in this cycle
        cmd_o.pop     = 1'b1;
        cmd_o.cap     = (cnt_q != SLOT_0);
        cmd_o.cap_idx = cnt_q - 2'd1;
        if (cnt_q == last_q) begin
          state_d = ST_LAST;
        end else begin
          cnt_d = cnt_q + 2'd1;
        end
      end
      ST_LAST: begin
        cmd_o.cap     = 1'b1;
        cmd_o.cap_idx = last_q;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
          ready_d      = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= SLOT_0;
      last_q  <= SLOT_0;
      ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
      ready_q <= ready_d;
    end
  end

endmodule

// ===== rtl/core/cfu_dp.sv =====
module cfu_dp
  import cfu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  input  logic [3:0]  req_type_i,
  input  logic [15:0] operand_i,
  input  logic [15:0] jump_word_i,
  input  logic [15:0] current_pc_i,
  input  logic [7:0]  flags_in_i,
  input  cfu_cmd_t    cmd_i,
  output cfu_stat_t   stat_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] next_pc_o,
  output logic [7:0]  flags_out_o,
  output logic [1:0]  branch_status_o,
  output logic [7:0]  stack_pointer_out_o
);

  logic [15:0] brk_tgt_q;
  logic [7:0]  sp_q, sp_d;
  logic [7:0]  sp_inc;

  logic [3:0]  req_q;
  logic [15:0] opnd_q;
  logic [15:0] jword_q;
  logic [15:0] pc_q;
  logic [7:0]  flags_q;
  logic [7:0]  pop_q [3];

  logic [15:0] ret_addr;
  logic [7:0]  push_data;
  logic [7:0]  ram_rdata;
  logic [STACK_AW-1:0] ram_addr;

  logic        out_valid_q;
  logic [15:0] npc_q, npc_d;
  logic [7:0]  fout_q, fout_d;
  logic [1:0]  sts_q, sts_d;
  logic [7:0]  spout_q;

  logic [15:0] br_target;
  logic        flag_bit;

  assign stat_o.in_op    = op_class(req_type_i);
  assign stat_o.out_free = ~out_valid_q | out_ready_i;

  assign sp_inc   = sp_q + 8'd1;
  assign ret_addr = pc_q + 16'd2;
  assign ram_addr = cmd_i.pop ? sp_inc[STACK_AW-1:0] : sp_q[STACK_AW-1:0];

  always_comb begin
    case (cmd_i.push_idx)
      SLOT_0:  push_data = ret_addr[15:8];
      SLOT_1:  push_data = ret_addr[7:0];
      default: push_data = flags_q;
    endcase
  end

  always_comb begin
    sp_d = sp_q;
    if (cmd_i.push) begin
      sp_d = sp_q - 8'd1;
    end else if (cmd_i.pop) begin
      sp_d = sp_inc;
    end
  end

  cfu_ram #(
    .WIDTH(8),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (cmd_i.push),
    .re_i   (cmd_i.pop),
    .addr_i (ram_addr),
    .wdata_i(push_data),
    .rdata_o(ram_rdata)
  );

  // branch condition: flag picked by the pair, wanted value in the low bit
  always_comb begin
    unique case (req_q) inside
      REQ_BCC, REQ_BCS: flag_bit = flags_q[0];
      REQ_BNE, REQ_BEQ: flag_bit = flags_q[1];
      REQ_BVC, REQ_BVS: flag_bit = flags_q[6];
      default:          flag_bit = flags_q[7];
    endcase
  end

  assign br_target = pc_q + {{8{opnd_q[7]}}, opnd_q[7:0]};

  always_comb begin
    npc_d  = pc_q;
    fout_d = flags_q;
    sts_d  = STS_NORMAL;
    unique case (req_q) inside
      REQ_JMP_ABS, REQ_JSR: npc_d = opnd_q;
      REQ_JMP_IND:          npc_d = jword_q;
      REQ_RTS:              npc_d = {pop_q[1], pop_q[0]};
      REQ_BRK:              npc_d = brk_tgt_q;
      REQ_RTI: begin
        npc_d  = {pop_q[2], pop_q[1]};
        fout_d = pop_q[0];
      end
      REQ_BCC, REQ_BCS, REQ_BNE, REQ_BEQ, REQ_BVC, REQ_BVS, REQ_BPL, REQ_BMI: begin
        if (flag_bit == req_q[0]) begin
          npc_d = br_target;
          sts_d = (br_target[15:8] == pc_q[15:8]) ? STS_TAKEN : STS_CROSS;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brk_tgt_q   <= '0;
      sp_q        <= 8'hFF;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        brk_tgt_q <= cfg_data_i;
      end
      sp_q <= sp_d;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q   <= req_type_i;
      opnd_q  <= operand_i;
      jword_q <= jump_word_i;
      pc_q    <= current_pc_i;
      flags_q <= flags_in_i;
    end
    if (cmd_i.cap) begin
      pop_q[cmd_i.cap_idx] <= ram_rdata;
    end
    if (cmd_i.finish) begin
      npc_q   <= npc_d;
      fout_q  <= fout_d;
      sts_q   <= sts_d;
      spout_q <= sp_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign next_pc_o           = npc_q;
  assign flags_out_o         = fout_q;
  assign branch_status_o     = sts_q;
  assign stack_pointer_out_o = spout_q;

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  import cfu_pkg::*;

  // request codes that the block treats as no operation
  localparam logic [3:0] REQ_SPARE_E = 4'd14;
  localparam logic [3:0] REQ_SPARE_F = 4'd15;
  localparam int DIR_ROWS   = 25;
  localparam int RAND_ITEMS = 175;
  localparam int HOLD_CYC   = 150;
  localparam int DRAIN_CYC  = 8;
  localparam int LIMIT_CYC  = 200000;

  typedef struct packed {
    logic [3:0]  req;
    logic [15:0] opnd;
    logic [15:0] jword;
    logic [15:0] pc;
    logic [7:0]  flg;
  } cf_instr_t;

  typedef struct packed {
    logic [15:0] npc;
    logic [7:0]  flg;
    logic [1:0]  sts;
    logic [7:0]  sp;
  } cf_outcome_t;

  typedef struct packed {
    cf_instr_t   instr;
    logic        typed;
    cf_outcome_t want;
  } cf_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_data_i;

  cfu_req_if req_if ();
  cfu_rsp_if rsp_if ();

  cpu6502_control_flow_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // predictor state
  logic [15:0] brk_target = 16'h0000;
  logic [7:0]  stk_ptr = 8'hFF;
  logic [7:0]  stk_mem [256];
  bit          stk_written [256];
  logic [3:0]  call_kinds [$];

  cf_outcome_t pending_flow_q [$];
  int          mismatch_cnt = 0;
  int unsigned cyc_cnt = 0;
  bit          quiet = 1'b0;
  bit          hold_go = 1'b0;

  // typed rows follow reset: break_target is still zero
  cf_row_t dir_tbl [DIR_ROWS] = '{
    '{'{REQ_JMP_ABS, 16'hFFFF, 16'h0000, 16'h0000, 8'hFF}, 1'b1,
      '{16'hFFFF, 8'hFF, STS_NORMAL, 8'hFF}},
    '{'{REQ_JMP_ABS, 16'h0000, 16'hFFFF, 16'hFFFF, 8'h00}, 1'b1,
      '{16'h0000, 8'h00, STS_NORMAL, 8'hFF}},
    '{'{REQ_JMP_IND, 16'h1234, 16'hFFFF, 16'h0000, 8'h00}, 1'b1,
      '{16'hFFFF, 8'h00, STS_NORMAL, 8'hFF}},
    '{'{REQ_JSR, 16'h8000, 16'h0000, 16'hFFFF, 8'h5A}, 1'b1,
      '{16'h8000, 8'h5A, STS_NORMAL, 8'hFD}},
    '{'{REQ_RTS, 16'h0000, 16'h0000, 16'h4000, 8'hA5}, 1'b1,
      '{16'h0001, 8'hA5, STS_NORMAL, 8'hFF}},
    '{'{REQ_BRK, 16'h0000, 16'h0000, 16'hFFFE, 8'hC3}, 1'b1,
      '{16'h0000, 8'hC3, STS_NORMAL, 8'hFC}},
    '{'{REQ_RTI, 16'h0000, 16'h0000, 16'h0000, 8'h00}, 1'b1,
      '{16'h0000, 8'hC3, STS_NORMAL, 8'hFF}},
    '{'{REQ_BCC, 16'h007F, 16'h0000, 16'h1080, 8'h00}, 1'b1,
      '{16'h10FF, 8'h00, STS_TAKEN, 8'hFF}},
    '{'{REQ_BCS, 16'h0080, 16'h0000, 16'h1000, 8'h01}, 1'b1,
      '{16'h0F80, 8'h01, STS_CROSS, 8'hFF}},
    '{'{REQ_BCC, 16'h0010, 16'h0000, 16'h1000, 8'h01}, 1'b1,
      '{16'h1000, 8'h01, STS_NORMAL, 8'hFF}},
    '{'{REQ_BNE, 16'hFF05, 16'h0000, 16'hFFFF, 8'h00}, 1'b1,
      '{16'h0004, 8'h00, STS_CROSS, 8'hFF}},
    '{'{REQ_BEQ, 16'h00FE, 16'h0000, 16'h0000, 8'h02}, 1'b1,
      '{16'hFFFE, 8'h02, STS_CROSS, 8'hFF}},
    '{'{REQ_BEQ, 16'h0010, 16'h0000, 16'h2000, 8'hFD}, 1'b1,
      '{16'h2000, 8'hFD, STS_NORMAL, 8'hFF}},
    '{'{REQ_BVC, 16'h0040, 16'h0000, 16'h3000, 8'hBF}, 1'b1,
      '{16'h3040, 8'hBF, STS_TAKEN, 8'hFF}},
    '{'{REQ_BVS, 16'h0001, 16'h0000, 16'h30FF, 8'h40}, 1'b1,
      '{16'h3100, 8'h40, STS_CROSS, 8'hFF}},
    '{'{REQ_BPL, 16'h0081, 16'h0000, 16'h4000, 8'h7F}, 1'b1,
      '{16'h3F81, 8'h7F, STS_CROSS, 8'hFF}},
    '{'{REQ_BMI, 16'h007F, 16'h0000, 16'h40FF, 8'h80}, 1'b1,
      '{16'h417E, 8'h80, STS_CROSS, 8'hFF}},
    '{'{REQ_BMI, 16'h0000, 16'h0000, 16'h5000, 8'h7F}, 1'b1,
      '{16'h5000, 8'h7F, STS_NORMAL, 8'hFF}},
    '{'{REQ_SPARE_E, 16'hFFFF, 16'hFFFF, 16'hABCD, 8'h55}, 1'b1,
      '{16'hABCD, 8'h55, STS_NORMAL, 8'hFF}},
    '{'{REQ_SPARE_F, 16'h0000, 16'h0000, 16'h0000, 8'hAA}, 1'b1,
      '{16'h0000, 8'hAA, STS_NORMAL, 8'hFF}},
    '{'{REQ_JSR, 16'hFFFF, 16'h0000, 16'h1234, 8'h00}, 1'b0,
      '{16'h0000, 8'h00, STS_NORMAL, 8'h00}},
    '{'{REQ_JSR, 16'h0000, 16'h0000, 16'hFFFE, 8'h11}, 1'b0,
      '{16'h0000, 8'h00, STS_NORMAL, 8'h00}},
    '{'{REQ_RTS, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF}, 1'b0,
      '{16'h0000, 8'h00, STS_NORMAL, 8'h00}},
    '{'{REQ_RTS, 16'h0000, 16'h0000, 16'h8000, 8'h00}, 1'b0,
      '{16'h0000, 8'h00, STS_NORMAL, 8'h00}},
    '{'{REQ_BVS, 16'h0080, 16'h0000, 16'h0050, 8'h40}, 1'b0,
      '{16'h0000, 8'h00, STS_NORMAL, 8'h00}}
  };

  function automatic void push_byte(input logic [7:0] v);
    stk_mem[stk_ptr] = v;
    stk_written[stk_ptr] = 1'b1;
    stk_ptr = stk_ptr - 8'd1;
  endfunction

  function automatic logic [7:0] pop_byte();
    stk_ptr = stk_ptr + 8'd1;
    return stk_mem[stk_ptr];
  endfunction

  function automatic logic [15:0] pop_addr();
    logic [7:0] lo;
    logic [7:0] hi;
    lo = pop_byte();
    hi = pop_byte();
    return {hi, lo};
  endfunction

  function automatic bit stack_filled(input int n);
    bit ok;
    ok = 1'b1;
    for (int k = 1; k <= n; k++) begin
      if (!stk_written[stk_ptr + 8'(k)]) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic cf_outcome_t predict_flow(input cf_instr_t it);
    cf_outcome_t o;
    logic [15:0] ret;
    logic [15:0] ofs;
    logic        flag_v;
    o = '{it.pc, it.flg, STS_NORMAL, 8'h00};
    ret = it.pc + 16'd2;
    flag_v = 1'b0;
    case (it.req)
      REQ_JMP_ABS: o.npc = it.opnd;
      REQ_JMP_IND: o.npc = it.jword;
      REQ_JSR: begin
        push_byte(ret[15:8]);
        push_byte(ret[7:0]);
        o.npc = it.opnd;
        call_kinds.push_back(REQ_JSR);
      end
      REQ_RTS: o.npc = pop_addr();
      REQ_BRK: begin
        push_byte(ret[15:8]);
        push_byte(ret[7:0]);
        push_byte(it.flg);
        o.npc = brk_target;
        call_kinds.push_back(REQ_BRK);
      end
      REQ_RTI: begin
        o.flg = pop_byte();
        o.npc = pop_addr();
      end
      REQ_BCC, REQ_BCS: flag_v = it.flg[0];
      REQ_BNE, REQ_BEQ: flag_v = it.flg[1];
      REQ_BVC, REQ_BVS: flag_v = it.flg[6];
      REQ_BPL, REQ_BMI: flag_v = it.flg[7];
      default: ;
    endcase
    if ((it.req == REQ_RTS || it.req == REQ_RTI) && call_kinds.size() != 0)
      call_kinds.pop_back();
    // odd branch codes go on a set flag, even ones on a clear flag
    if (it.req >= REQ_BCC && it.req <= REQ_BMI && flag_v == it.req[0]) begin
      ofs = {{8{it.opnd[7]}}, it.opnd[7:0]};
      o.npc = it.pc + ofs;
      o.sts = (o.npc[15:8] == it.pc[15:8]) ? STS_TAKEN : STS_CROSS;
    end
    o.sp = stk_ptr;
    return o;
  endfunction

  function automatic cf_instr_t gen_instr();
    cf_instr_t   it;
    int unsigned pick;
    it.opnd  = 16'($urandom);
    it.jword = 16'($urandom);
    it.pc    = 16'($urandom);
    it.flg   = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 10) begin
      it.req = $urandom_range(1) ? REQ_JMP_IND : REQ_JMP_ABS;
    end else if (pick < 25) begin
      it.req = REQ_JSR;
    end else if (pick < 35) begin
      it.req = REQ_BRK;
    end else if (pick < 60) begin
      // mostly unwind the latest call, sometimes pop the other kind
      if (call_kinds.size() != 0 && $urandom_range(4) != 0)
        it.req = (call_kinds[$] == REQ_JSR) ? REQ_RTS : REQ_RTI;
      else
        it.req = $urandom_range(1) ? REQ_RTI : REQ_RTS;
      // never pop a byte that was never pushed
      if (!stack_filled((it.req == REQ_RTI) ? 3 : 2)) it.req = REQ_JSR;
    end else if (pick < 94) begin
      it.req = REQ_BCC + 4'($urandom_range(7));
    end else begin
      it.req = $urandom_range(1) ? REQ_SPARE_F : REQ_SPARE_E;
    end
    return it;
  endfunction

  task automatic issue(input cf_instr_t it, input logic typed, input cf_outcome_t want);
    cf_outcome_t pred;
    if (!quiet) begin
      while ($urandom_range(99) < 18) begin
        req_if.valid      <= 1'b0;
        req_if.req_type   <= 4'($urandom);
        req_if.operand    <= 16'($urandom);
        req_if.current_pc <= 16'($urandom);
        @(posedge clk_i);
      end
    end
    req_if.valid      <= 1'b1;
    req_if.req_type   <= it.req;
    req_if.operand    <= it.opnd;
    req_if.jump_word  <= it.jword;
    req_if.current_pc <= it.pc;
    req_if.flags_in   <= it.flg;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    pred = predict_flow(it);
    pending_flow_q.push_back(typed ? want : pred);
  endtask

  task automatic drain();
    while (pending_flow_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic cmp_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    cf_outcome_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_flow_q.size() == 0) begin
        $error("result with no request outstanding: next_pc %h", rsp_if.next_pc);
        mismatch_cnt++;
      end else begin
        want = pending_flow_q.pop_front();
        cmp_field("next_pc", want.npc, rsp_if.next_pc);
        cmp_field("flags_out", 16'(want.flg), 16'(rsp_if.flags_out));
        cmp_field("branch_status", 16'(want.sts), 16'(rsp_if.branch_status));
        cmp_field("stack_pointer_out", 16'(want.sp), 16'(rsp_if.stack_pointer_out));
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > LIMIT_CYC) begin
      $display("cpu6502_control_flow_unit test failed");
      $finish;
    end
  end

  // response side, with its own hold-off counter
  initial begin
    int hold_left;
    hold_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_go) begin
        hold_go = 1'b0;
        hold_left = HOLD_CYC;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (quiet) begin
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= 18);
      end
    end
  end

  initial begin
    logic [15:0] tgt;
    rst_ni = 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_data_i        <= 16'h0000;
    req_if.valid      <= 1'b0;
    req_if.req_type   <= REQ_JMP_ABS;
    req_if.operand    <= 16'h0000;
    req_if.jump_word  <= 16'h0000;
    req_if.current_pc <= 16'h0000;
    req_if.flags_in   <= 8'h00;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      issue(dir_tbl[i].instr, dir_tbl[i].typed, dir_tbl[i].want);
    end
    req_if.valid <= 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0:       tgt = 16'hFFFF;
        1:       tgt = 16'($urandom);
        2:       tgt = 16'h0000;
        default: tgt = 16'h8001;
      endcase
      cfg_we_i   <= 1'b1;
      cfg_data_i <= tgt;
      brk_target = tgt;
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      quiet = (ph == 2);
      // long response stall while requests keep coming
      if (ph == 1) hold_go = 1'b1;
      for (int n = 0; n < RAND_ITEMS; n++) begin
        issue(gen_instr(), 1'b0, '0);
      end
      req_if.valid <= 1'b0;
    end

    drain();
    if (mismatch_cnt == 0 && pending_flow_q.size() == 0) begin
      $display("cpu6502_control_flow_unit test passed");
    end else begin
      $display("cpu6502_control_flow_unit test failed");
    end
    $finish;
  end

endmodule
